// ----- hdl/snt_pkg.sv -----
package snt_pkg;

    localparam int OP_W    = 2;
    localparam int KEY_W   = 64;
    localparam int STAT_W  = 3;
    localparam int POS_W   = 5;
    localparam int HELD_W  = 6;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_CREATED  = 3'd0,
        ST_EXISTS   = 3'd1,
        ST_FULL     = 3'd2,
        ST_DELETED  = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_EMPTY    = 3'd5,
        ST_FOUND    = 3'd6,
        ST_LISTED   = 3'd7
    } status_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic move_rd;
        logic move_wr;
        logic result;
        logic list_rd;
        logic list_ld;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic occ_zero;
        logic scan_done;
        logic hit;
        logic out_free;
        logic list_last;
    } dp_stat_t;

endpackage

// ----- hdl/snt_ram.sv -----
module snt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/snt_dpath.sv -----
module snt_dpath #(
    parameter int CAPACITY = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  snt_pkg::dp_cmd_t            cmd,
    output snt_pkg::dp_stat_t           stat,
    input  logic [snt_pkg::OP_W-1:0]    operation,
    input  logic [snt_pkg::KEY_W-1:0]   name_key,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [snt_pkg::STAT_W-1:0]  status,
    output logic [snt_pkg::KEY_W-1:0]   entry_key,
    output logic [snt_pkg::POS_W-1:0]   entry_position,
    output logic [snt_pkg::HELD_W-1:0]  entries_held,
    output logic                        last
);
    import snt_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int OCC_W = $clog2(CAPACITY + 1);

    op_t              op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] rd_idx_reg;
    logic [AW-1:0]    cmp_idx_reg;
    logic             cmp_vld_reg;
    logic             hit_reg;
    logic [AW-1:0]    hit_idx_reg;
    logic             rsp_valid_reg;
    status_t          status_reg;
    logic [KEY_W-1:0] entry_key_reg;
    logic [POS_W-1:0] pos_reg;
    logic [HELD_W-1:0] held_reg;
    logic             last_reg;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [KEY_W-1:0] wdata;
    logic             re;
    logic [AW-1:0]    raddr;
    logic [KEY_W-1:0] rdata;

    logic             issue;
    logic             full;
    logic             create_ok;
    logic             out_free;
    logic             load;
    logic [OCC_W-1:0] occ_inc;
    logic [OCC_W-1:0] occ_dec;
    logic [OCC_W-1:0] rd_idx_inc;

    logic [AW+POS_W-1:0]     hit_pos_ext;
    logic [AW+POS_W-1:0]     occ_pos_ext;
    logic [AW+POS_W-1:0]     list_pos_ext;
    logic [OCC_W+HELD_W-1:0] occ_held_ext;
    logic [OCC_W+HELD_W-1:0] inc_held_ext;

    status_t           res_status;
    logic [KEY_W-1:0]  res_key;
    logic [POS_W-1:0]  res_pos;
    logic [HELD_W-1:0] res_held;
    logic              res_last;

    assign occ_inc    = occ_reg + OCC_W'(1);
    assign occ_dec    = occ_reg - OCC_W'(1);
    assign rd_idx_inc = rd_idx_reg + OCC_W'(1);
    assign full       = (occ_reg == OCC_W'(CAPACITY));
    assign issue      = cmd.scan && !hit_reg && (rd_idx_reg < occ_reg);
    assign create_ok  = (op_reg == OP_CREATE) && !hit_reg && !full;
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign load       = cmd.result || cmd.list_ld;

    assign hit_pos_ext  = {{POS_W{1'b0}}, hit_idx_reg};
    assign occ_pos_ext  = {{POS_W{1'b0}}, occ_reg[AW-1:0]};
    assign list_pos_ext = {{POS_W{1'b0}}, rd_idx_reg[AW-1:0]};
    assign occ_held_ext = {{HELD_W{1'b0}}, occ_reg};
    assign inc_held_ext = {{HELD_W{1'b0}}, occ_inc};

    assign we    = cmd.move_wr || (cmd.result && create_ok);
    assign waddr = cmd.move_wr ? hit_idx_reg : occ_reg[AW-1:0];
    assign wdata = cmd.move_wr ? rdata : key_reg;
    assign re    = issue || cmd.move_rd || cmd.list_rd;
    assign raddr = cmd.move_rd ? occ_dec[AW-1:0] : rd_idx_reg[AW-1:0];

    snt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        res_status = ST_NOTFOUND;
        res_key    = key_reg;
        res_pos    = '0;
        res_held   = occ_held_ext[HELD_W-1:0];
        res_last   = 1'b1;
        if (cmd.list_ld)
        begin
            res_status = ST_LISTED;
            res_key    = rdata;
            res_pos    = list_pos_ext[POS_W-1:0];
            res_last   = stat.list_last;
        end
        else
        begin
            case (op_reg)
                OP_CREATE:
                begin
                    if (hit_reg)
                    begin
                        res_status = ST_EXISTS;
                        res_pos    = hit_pos_ext[POS_W-1:0];
                    end
                    else if (full)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        res_status = ST_CREATED;
                        res_pos    = occ_pos_ext[POS_W-1:0];
                        res_held   = inc_held_ext[HELD_W-1:0];
                    end
                end
                OP_DELETE:
                begin
                    if (hit_reg)
                    begin
                        // The count was already lowered when the last entry moved.
                        res_status = ST_DELETED;
                        res_pos    = hit_pos_ext[POS_W-1:0];
                    end
                    else if (occ_reg == '0)
                    begin
                        res_status = ST_EMPTY;
                    end
                end
                OP_SEARCH:
                begin
                    if (hit_reg)
                    begin
                        res_status = ST_FOUND;
                        res_pos    = hit_pos_ext[POS_W-1:0];
                    end
                end
                default:
                begin
                    res_status = ST_EMPTY;
                    res_key    = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= issue;
            if (cmd.start)
            begin
                rd_idx_reg <= '0;
                hit_reg    <= 1'b0;
            end
            else if (issue || cmd.list_ld)
            begin
                rd_idx_reg <= rd_idx_inc;
            end
            if (cmp_vld_reg && !hit_reg && (rdata == key_reg))
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.move_wr)
            begin
                occ_reg <= occ_dec;
            end
            else if (cmd.result && create_ok)
            begin
                occ_reg <= occ_inc;
            end
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg  <= op_t'(operation);
            key_reg <= name_key;
        end
        if (issue)
        begin
            cmp_idx_reg <= rd_idx_reg[AW-1:0];
        end
        if (cmp_vld_reg && !hit_reg && (rdata == key_reg))
        begin
            hit_idx_reg <= cmp_idx_reg;
        end
        if (load)
        begin
            status_reg    <= res_status;
            entry_key_reg <= res_key;
            pos_reg       <= res_pos;
            held_reg      <= res_held;
            last_reg      <= res_last;
        end
    end

    assign stat.op        = op_reg;
    assign stat.occ_zero  = (occ_reg == '0);
    assign stat.scan_done = hit_reg || ((rd_idx_reg == occ_reg) && !cmp_vld_reg);
    assign stat.hit       = hit_reg;
    assign stat.out_free  = out_free;
    assign stat.list_last = (rd_idx_inc == occ_reg);

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign entry_key      = entry_key_reg;
    assign entry_position = pos_reg;
    assign entries_held   = held_reg;
    assign last           = last_reg;

endmodule

// ----- hdl/snt_ctrl.sv -----
module snt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output snt_pkg::dp_cmd_t   cmd,
    input  snt_pkg::dp_stat_t  stat
);
    import snt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_RESULT,
        S_LIST_RD,
        S_LIST_LD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.op == OP_LIST)
                begin
                    state_next = stat.occ_zero ? S_RESULT : S_LIST_RD;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    if ((stat.op == OP_DELETE) && stat.hit)
                    begin
                        state_next = S_MOVE_RD;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_MOVE_RD:
            begin
                cmd.move_rd = 1'b1;
                state_next  = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                cmd.move_wr = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LIST_RD:
            begin
                cmd.list_rd = 1'b1;
                state_next  = S_LIST_LD;
            end
            S_LIST_LD:
            begin
                if (stat.out_free)
                begin
                    cmd.list_ld = 1'b1;
                    state_next  = stat.list_last ? S_IDLE : S_LIST_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

endmodule

// ----- hdl/single_level_name_table.sv -----
// Table of up to CAPACITY unique 64-bit name keys that takes create, delete, search and
// list requests, one at a time. Create, delete and search scan the stored keys from slot
// zero through one read port of the key memory, one key per cycle; a delete that hits
// then moves the last entry into the freed slot. A list gives one result beat per held
// entry (one empty beat when none is held), loading each beat once the output is free,
// and marks the final beat with last. The key memory needs no clearing after reset, and
// a new request is taken while the previous result beat still waits.
module single_level_name_table #(
    parameter int CAPACITY = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [snt_pkg::OP_W-1:0]    operation,
    input  logic [snt_pkg::KEY_W-1:0]   name_key,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [snt_pkg::STAT_W-1:0]  status,
    output logic [snt_pkg::KEY_W-1:0]   entry_key,
    output logic [snt_pkg::POS_W-1:0]   entry_position,
    output logic [snt_pkg::HELD_W-1:0]  entries_held,
    output logic                        last
);
    import snt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    snt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    snt_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .operation      (operation),
        .name_key       (name_key),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .entry_key      (entry_key),
        .entry_position (entry_position),
        .entries_held   (entries_held),
        .last           (last)
    );

endmodule

// ----- tb/name_table_checker.sv -----
module name_table_checker #(
    parameter int CAPACITY = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  logic [snt_pkg::OP_W-1:0]    operation,
    input  logic [snt_pkg::KEY_W-1:0]   name_key,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic [snt_pkg::STAT_W-1:0]  status,
    input  logic [snt_pkg::KEY_W-1:0]   entry_key,
    input  logic [snt_pkg::POS_W-1:0]   entry_position,
    input  logic [snt_pkg::HELD_W-1:0]  entries_held,
    input  logic                        last,
    output int                          fault_count,
    output int                          beats_due
);
    import snt_pkg::*;

    typedef struct {
        status_t            code;
        logic [KEY_W-1:0]   key;
        logic [POS_W-1:0]   slot;
        logic [HELD_W-1:0]  held;
        logic               fin;
    } rsp_beat_t;

    rsp_beat_t          beats_owed[$];
    logic [KEY_W-1:0]   shadow_keys [CAPACITY];
    int unsigned        shadow_count = 0;

    function automatic void owe(status_t code, logic [KEY_W-1:0] key, int unsigned slot,
                                int unsigned held, logic fin);
        rsp_beat_t b;
        b.code = code;
        b.key = key;
        b.slot = POS_W'(slot);
        b.held = HELD_W'(held);
        b.fin = fin;
        beats_owed.push_back(b);
    endfunction

    // The first matching slot from zero upward wins.
    function automatic int lookup(logic [KEY_W-1:0] key);
        for (int i = 0; i < int'(shadow_count); i++)
        begin
            if (shadow_keys[i] == key)
                return i;
        end
        return -1;
    endfunction

    function automatic void apply_request(op_t op, logic [KEY_W-1:0] key);
        int hit;
        hit = lookup(key);
        case (op)
            OP_CREATE:
            begin
                if (hit >= 0)
                    owe(ST_EXISTS, key, hit, shadow_count, 1'b1);
                else if (shadow_count >= CAPACITY)
                    owe(ST_FULL, key, 0, shadow_count, 1'b1);
                else
                begin
                    shadow_keys[shadow_count] = key;
                    shadow_count++;
                    owe(ST_CREATED, key, shadow_count - 1, shadow_count, 1'b1);
                end
            end
            OP_DELETE:
            begin
                if (shadow_count == 0)
                    owe(ST_EMPTY, key, 0, 0, 1'b1);
                else if (hit >= 0)
                begin
                    shadow_keys[hit] = shadow_keys[shadow_count - 1];
                    shadow_count--;
                    owe(ST_DELETED, key, hit, shadow_count, 1'b1);
                end
                else
                    owe(ST_NOTFOUND, key, 0, shadow_count, 1'b1);
            end
            OP_SEARCH:
            begin
                if (hit >= 0)
                    owe(ST_FOUND, key, hit, shadow_count, 1'b1);
                else
                    owe(ST_NOTFOUND, key, 0, shadow_count, 1'b1);
            end
            default:
            begin
                if (shadow_count == 0)
                    owe(ST_EMPTY, '0, 0, 0, 1'b1);
                else
                begin
                    for (int unsigned i = 0; i < shadow_count; i++)
                        owe(ST_LISTED, shadow_keys[i], i, shadow_count, i + 1 == shadow_count);
                end
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        rsp_beat_t want;
        if (!rst_n)
        begin
            fault_count = 0;
        end
        else
        begin
            if (req_valid && req_ready)
                apply_request(op_t'(operation), name_key);
            if (rsp_valid && rsp_ready)
            begin
                if (beats_owed.size() == 0)
                begin
                    $display("%0t: no beat expected, got", $time);
                    $display("%0t:   status=%0d key=%h pos=%0d held=%0d last=%0b",
                             $time, status, entry_key, entry_position, entries_held, last);
                    fault_count++;
                end
                else
                begin
                    want = beats_owed.pop_front();
                    if (status !== want.code || entry_key !== want.key
                        || entry_position !== want.slot || entries_held !== want.held
                        || last !== want.fin)
                    begin
                        $display("%0t: expected status=%0d key=%h pos=%0d held=%0d last=%0b",
                                 $time, want.code, want.key, want.slot, want.held, want.fin);
                        $display("%0t:   actual status=%0d key=%h pos=%0d held=%0d last=%0b",
                                 $time, status, entry_key, entry_position, entries_held, last);
                        fault_count++;
                    end
                end
            end
        end
        beats_due = beats_owed.size();
    end

endmodule

// ----- tb/single_level_name_table_test.sv -----
module single_level_name_table_test;

    import snt_pkg::*;

    localparam int CAPACITY  = 32;
    localparam int POOL_SIZE = 48;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    logic [OP_W-1:0]    operation;
    logic [KEY_W-1:0]   name_key;
    logic               rsp_valid;
    logic               rsp_ready;
    logic [STAT_W-1:0]  status;
    logic [KEY_W-1:0]   entry_key;
    logic [POS_W-1:0]   entry_position;
    logic [HELD_W-1:0]  entries_held;
    logic               last;

    int                 fault_count;
    int                 beats_due;
    int                 send_idle_pct = 0;
    int                 rsp_stall_pct = 0;
    int                 rsp_hold_left = 0;
    logic [KEY_W-1:0]   key_pool [POOL_SIZE];

    single_level_name_table #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .operation(operation),
        .name_key(name_key),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .status(status),
        .entry_key(entry_key),
        .entry_position(entry_position),
        .entries_held(entries_held),
        .last(last)
    );

    name_table_checker #(
        .CAPACITY(CAPACITY)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .operation(operation),
        .name_key(name_key),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .status(status),
        .entry_key(entry_key),
        .entry_position(entry_position),
        .entries_held(entries_held),
        .last(last),
        .fault_count(fault_count),
        .beats_due(beats_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // A long hold-off is counted down here, one cycle per clock.
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_left > 0)
            begin
                rsp_ready <= 1'b0;
                rsp_hold_left--;
            end
            else
                rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 80)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        return {$urandom(), $urandom()};
    endfunction

    function automatic op_t pick_op(int create_w, int delete_w, int search_w);
        int roll;
        roll = $urandom_range(99);
        if (roll < create_w)
            return OP_CREATE;
        if (roll < create_w + delete_w)
            return OP_DELETE;
        if (roll < create_w + delete_w + search_w)
            return OP_SEARCH;
        return OP_LIST;
    endfunction

    task automatic send_req(op_t op, logic [KEY_W-1:0] key);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        name_key <= key;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic run_mix(int count, int create_w, int delete_w, int search_w);
        repeat (count) send_req(pick_op(create_w, delete_w, search_w), pick_key());
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (beats_due != 0);
        @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        operation = OP_CREATE;
        name_key = '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom(), $urandom()};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_req(OP_LIST, '0);
        send_req(OP_DELETE, '1);
        send_req(OP_SEARCH, '0);
        send_req(OP_CREATE, '0);
        send_req(OP_CREATE, '1);
        send_req(OP_CREATE, 64'h5555_5555_5555_5555);
        send_req(OP_CREATE, 64'haaaa_aaaa_aaaa_aaaa);
        send_req(OP_CREATE, '1);
        send_req(OP_SEARCH, '1);
        send_req(OP_SEARCH, 64'h0123_4567_89ab_cdef);
        send_req(OP_LIST, '1);
        send_req(OP_DELETE, '0);
        send_req(OP_DELETE, 64'h5555_5555_5555_5555);
        send_req(OP_DELETE, 64'h0123_4567_89ab_cdef);
        send_req(OP_SEARCH, 64'haaaa_aaaa_aaaa_aaaa);
        send_req(OP_LIST, 64'h0f0f_0f0f_0f0f_0f0f);

        run_mix(40, 65, 10, 15);

        send_idle_pct = 85;
        for (int i = 0; i < POOL_SIZE; i++)
            send_req(OP_CREATE, key_pool[i]);
        send_req(OP_LIST, pick_key());
        send_idle_pct = 0;

        rsp_stall_pct = 85;
        run_mix(50, 35, 30, 25);
        rsp_stall_pct = 0;

        // The receiver holds off while requests keep coming, so the table backs up.
        rsp_hold_left = 400;
        run_mix(20, 40, 20, 30);

        send_idle_pct = 9;
        rsp_stall_pct = 9;
        run_mix(40, 15, 60, 15);
        send_idle_pct = 0;
        rsp_stall_pct = 0;

        drain();
        run_mix(20, 30, 30, 30);
        send_req(OP_LIST, pick_key());

        drain();
        repeat (2 * CAPACITY + 20) @(posedge clk);
        if (fault_count == 0 && beats_due == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/snt_pkg.sv
hdl/snt_ram.sv
hdl/snt_dpath.sv
hdl/snt_ctrl.sv
hdl/single_level_name_table.sv
tb/name_table_checker.sv
tb/single_level_name_table_test.sv
